// ===== hw/rtl/aifp_pkg.sv =====
// Package with the types, constants and helper functions of the ASCII integer field parser.
package aifp_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 7;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RADIX       = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PAD_ZERO    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALLOW_MINUS = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESULT_SIZE = 3'd4;

    localparam logic [5:0] RADIX_RESET       = 6'd10;
    localparam logic       PAD_ZERO_RESET    = 1'b0;
    localparam logic [6:0] MAX_WIDTH_RESET   = 7'd0;
    localparam logic       ALLOW_MINUS_RESET = 1'b1;
    localparam logic [1:0] RESULT_SIZE_RESET = 2'd1;

    localparam logic [5:0] RADIX_MIN  = 6'd2;
    localparam logic [5:0] RADIX_MAX  = 6'd36;
    localparam logic [5:0] DIGIT_NONE = 6'd36;
    localparam logic [6:0] FIELD_WIDTH_MAX = 7'd64;

    localparam logic [1:0] SIZE_16 = 2'd0;
    localparam logic [1:0] SIZE_64 = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_BLANK  = 2'd1,
        PH_PAD    = 2'd2,
        PH_DIGITS = 2'd3
    } phase_t;

    typedef struct packed {
        logic [5:0] radix;
        logic       pad_zero;
        logic [6:0] max_width;
        logic       allow_minus;
        logic [1:0] result_size;
    } aifp_cfg_t;

    // Returns the digit value 0 to 35, or DIGIT_NONE for a character that is not alphanumeric.
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = {2'b00, DIGIT_NONE};
        if (c inside {[CH_ZERO:CH_NINE]})
        begin
            d = c - CH_ZERO;
        end
        else if (c inside {[CH_UPPER_A:CH_UPPER_Z]})
        begin
            d = c - CH_UPPER_A + 8'd10;
        end
        else if (c inside {[CH_LOWER_A:CH_LOWER_Z]})
        begin
            d = c - CH_LOWER_A + 8'd10;
        end
        return d[5:0];
    endfunction

endpackage

// ===== hw/rtl/aifp_if.sv =====
// Valid/ready channel interfaces for the character items and the result items.
interface aifp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface aifp_result_if #(
    parameter int VALUE_WIDTH = 64
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   converted;

    modport source (output valid, output value, output converted, input ready);
    modport sink (input valid, input value, input converted, output ready);
endinterface

// ===== hw/rtl/ascii_integer_field_parser.sv =====
// Top level of the ASCII integer field parser with input register, result register and config.
// Throughput is one character per cycle unless stalled; each step updates the field state.
// A field's end character passes the input register; its result item is then registered.
// The input stalls only while the result register is full and its item is not being taken.
// Reset clears the field state and loads the configuration registers with their defaults.
module ascii_integer_field_parser
    import aifp_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    aifp_char_if.sink                  chars,
    aifp_result_if.source              results
);

    aifp_cfg_t              cfg_reg;
    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_converted_reg;

    logic                   step;
    logic                   emit;
    logic [VALUE_WIDTH-1:0] core_value;
    logic                   core_converted;

    assign step          = in_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready   = !in_valid_reg || step;
    assign results.valid = out_valid_reg;
    assign results.value = out_value_reg;
    assign results.converted = out_converted_reg;

    aifp_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_in   (in_char_reg),
        .cfg       (cfg_reg),
        .emit      (emit),
        .value     (core_value),
        .converted (core_converted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radix       <= RADIX_RESET;
            cfg_reg.pad_zero    <= PAD_ZERO_RESET;
            cfg_reg.max_width   <= MAX_WIDTH_RESET;
            cfg_reg.allow_minus <= ALLOW_MINUS_RESET;
            cfg_reg.result_size <= RESULT_SIZE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_RADIX:       cfg_reg.radix       <= cfg_data[5:0];
                CFG_PAD_ZERO:    cfg_reg.pad_zero    <= cfg_data[0];
                CFG_MAX_WIDTH:   cfg_reg.max_width   <= cfg_data[6:0];
                CFG_ALLOW_MINUS: cfg_reg.allow_minus <= cfg_data[0];
                CFG_RESULT_SIZE: cfg_reg.result_size <= cfg_data[1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (chars.valid && chars.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            in_char_reg <= chars.char_in;
        end
        if (step && emit)
        begin
            out_value_reg     <= core_value;
            out_converted_reg <= core_converted;
        end
    end

endmodule

// ===== hw/rtl/aifp_core.sv =====
// Field state machine and radix accumulator that consume one character per step.
module aifp_core
    import aifp_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             char_in,
    input  aifp_cfg_t              cfg,
    output logic                   emit,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   converted
);

    phase_t                 phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [6:0]             width_left_reg, width_left_next;
    logic                   negative_reg, negative_next;
    logic                   digit_seen_reg, digit_seen_next;

    logic                   is_term, is_sep, is_blank, is_zero, is_minus, is_alnum;
    logic [5:0]             dval, radix_eff, dclamp;
    logic [6:0]             width_eff, width_cur;
    logic                   digit_path, take_digit, last_digit;
    logic [VALUE_WIDTH-1:0] acc_step, acc_src, signed_val;
    logic [VALUE_WIDTH-1:0] keep_mask;

    assign is_term  = (char_in == CH_NUL) || (char_in == CH_CR) || (char_in == CH_LF)
                   || (char_in == CH_FF);
    assign is_blank = (char_in == CH_SPACE) || (char_in == CH_TAB);
    assign is_sep   = is_blank || (char_in == CH_COMMA);
    assign is_zero  = (char_in == CH_ZERO);
    assign is_minus = (char_in == CH_MINUS) && cfg.allow_minus;
    assign dval     = digit_of(char_in);
    assign is_alnum = (dval != DIGIT_NONE);

    assign radix_eff = (cfg.radix < RADIX_MIN) ? RADIX_MIN
                     : ((cfg.radix > RADIX_MAX) ? RADIX_MAX : cfg.radix);
    assign dclamp    = (dval >= radix_eff) ? (radix_eff - 6'd1) : dval;
    assign width_eff = (cfg.max_width == 7'd0) ? FIELD_WIDTH_MAX : cfg.max_width;
    assign width_cur = (phase_reg == PH_FIRST) ? width_eff : width_left_reg;

    // The digit part is reached directly from every phase unless a leading character is skipped.
    always_comb
    begin
        digit_path = 1'b0;
        case (phase_reg)
            PH_FIRST:  digit_path = is_alnum && !(cfg.pad_zero && is_zero);
            PH_BLANK:  digit_path = !is_blank && !(cfg.pad_zero && is_zero);
            PH_PAD:    digit_path = !is_zero;
            PH_DIGITS: digit_path = 1'b1;
            default:   digit_path = 1'b0;
        endcase
        digit_path = digit_path && !is_term;
    end

    assign take_digit = digit_path && !is_sep && !is_minus && is_alnum;
    assign last_digit = take_digit && (width_cur <= 7'd1);
    assign acc_step   = acc_reg * {{(VALUE_WIDTH-6){1'b0}}, radix_eff}
                      + {{(VALUE_WIDTH-6){1'b0}}, dclamp};

    // Result outputs.
    always_comb
    begin
        emit       = step && (is_term || (digit_path && is_sep) || last_digit);
        converted  = last_digit || digit_seen_reg;
        acc_src    = last_digit ? acc_step : acc_reg;
        signed_val = negative_reg ? (~acc_src + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : acc_src;
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            keep_mask[i] = (i < 16) || ((i < 32) && (cfg.result_size != SIZE_16))
                        || (cfg.result_size == SIZE_64);
        end
        value = converted ? (signed_val & keep_mask) : '0;
    end

    // Next field state.
    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        width_left_next = width_left_reg;
        negative_next   = negative_reg;
        digit_seen_next = digit_seen_reg;
        if (emit)
        begin
            phase_next      = PH_FIRST;
            acc_next        = '0;
            width_left_next = width_eff;
            negative_next   = 1'b0;
            digit_seen_next = 1'b0;
        end
        else if (step)
        begin
            width_left_next = width_cur;
            if (digit_path)
            begin
                phase_next = PH_DIGITS;
                if (is_minus)
                begin
                    negative_next = 1'b1;
                end
                else if (!is_alnum)
                begin
                    width_left_next = (width_cur > 7'd0) ? (width_cur - 7'd1) : 7'd0;
                end
                else
                begin
                    acc_next        = acc_step;
                    digit_seen_next = 1'b1;
                    width_left_next = width_cur - 7'd1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        phase_next = is_alnum ? PH_PAD : PH_BLANK;
                    end
                    PH_BLANK:
                    begin
                        phase_next = is_blank ? PH_BLANK : PH_PAD;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            acc_reg        <= '0;
            width_left_reg <= FIELD_WIDTH_MAX;
            negative_reg   <= 1'b0;
            digit_seen_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            width_left_reg <= width_left_next;
            negative_reg   <= negative_next;
            digit_seen_reg <= digit_seen_next;
        end
    end

endmodule

// ===== hw/rtl/aifp_checker.sv =====
// Port-level assertions for the ASCII integer field parser and the bind that attaches them.
module aifp_checker
    import aifp_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   chars_valid,
    input logic                   chars_ready,
    input logic                   results_valid,
    input logic                   results_ready,
    input logic [VALUE_WIDTH-1:0] results_value,
    input logic                   results_converted
);

    // A result that is not taken keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid && $stable(results_value)
            && $stable(results_converted))
        else $error("Stalled result item changed.");

    // A field without digits reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_converted |-> results_value == '0)
        else $error("Result item without digits has a nonzero value.");

    // A new result is preceded by an accepted character item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results_valid) |-> $past(chars_valid && chars_ready, 2))
        else $error("Result item appeared without an accepted character item.");

    // The character input stalls only behind a full, stalled result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !chars_ready |-> results_valid && !results_ready)
        else $error("Character input stalled while the result side was free.");

endmodule

bind ascii_integer_field_parser aifp_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_aifp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .chars_valid       (chars.valid),
    .chars_ready       (chars.ready),
    .results_valid     (results.valid),
    .results_ready     (results.ready),
    .results_value     (results.value),
    .results_converted (results.converted)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the ASCII integer field parser: directed and random character streams.
module tb;
    import aifp_pkg::*;

    localparam int TARGET_CHARS = 1250;
    localparam int MAX_IDLE = 18;

    typedef struct packed {
        logic [63:0] value;
        logic        converted;
    } field_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    aifp_char_if chars_if ();
    aifp_result_if #(.VALUE_WIDTH(64)) results_if ();

    ascii_integer_field_parser #(
        .VALUE_WIDTH(64)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .chars(chars_if),
        .results(results_if)
    );

    aifp_cfg_t     settings;
    phase_t        fp_phase;
    logic [63:0]   fp_acc;
    logic [6:0]    fp_width_left;
    logic          fp_negative;
    logic          fp_digit_seen;
    field_result_t pending_fields[$];

    int mismatches;
    int chars_sent;
    int fields_checked;
    int settings_used;
    int hold_cycles;
    bit sender_idles;
    bit receiver_stalls;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** ascii_integer_field_parser: FAILED **");
        $finish;
    end

    function automatic logic [6:0] field_width();
        return (settings.max_width == 7'd0) ? FIELD_WIDTH_MAX : settings.max_width;
    endfunction

    function automatic logic [5:0] effective_radix();
        if (settings.radix < RADIX_MIN)
        begin
            return RADIX_MIN;
        end
        if (settings.radix > RADIX_MAX)
        begin
            return RADIX_MAX;
        end
        return settings.radix;
    endfunction

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            return 6'(c - CH_ZERO);
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            return 6'(c - CH_UPPER_A + 8'd10);
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            return 6'(c - CH_LOWER_A + 8'd10);
        end
        return DIGIT_NONE;
    endfunction

    function automatic void clear_field_state();
        fp_phase      = PH_FIRST;
        fp_acc        = '0;
        fp_width_left = field_width();
        fp_negative   = 1'b0;
        fp_digit_seen = 1'b0;
    endfunction

    function automatic field_result_t close_field();
        field_result_t r;
        logic [63:0]   v;
        v = '0;
        if (fp_digit_seen)
        begin
            v = fp_acc;
            if (fp_negative)
            begin
                v = 64'd0 - v;
            end
            if (settings.result_size == SIZE_16)
            begin
                v = {48'd0, v[15:0]};
            end
            else if (settings.result_size != SIZE_64)
            begin
                v = {32'd0, v[31:0]};
            end
        end
        r.value     = v;
        r.converted = fp_digit_seen;
        clear_field_state();
        return r;
    endfunction

    // Returns 1 when the character ends a field; r then holds the parsed field.
    function automatic bit parse_char(input logic [7:0] c, output field_result_t r);
        logic [5:0] d;
        logic [5:0] rad;
        bit         leading;
        r       = '0;
        rad     = effective_radix();
        leading = 1'b0;
        if (c == CH_NUL || c == CH_CR || c == CH_LF || c == CH_FF)
        begin
            r = close_field();
            return 1'b1;
        end
        case (fp_phase)
            PH_FIRST:
            begin
                fp_width_left = field_width();
                if (digit_value(c) == DIGIT_NONE)
                begin
                    fp_phase = PH_BLANK;
                    return 1'b0;
                end
                leading = 1'b1;
            end
            PH_BLANK:
            begin
                if (c == CH_SPACE || c == CH_TAB)
                begin
                    return 1'b0;
                end
                leading = 1'b1;
            end
            PH_PAD:
            begin
                if (c == CH_ZERO)
                begin
                    return 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (leading && settings.pad_zero && c == CH_ZERO)
        begin
            fp_phase = PH_PAD;
            return 1'b0;
        end
        fp_phase = PH_DIGITS;
        if (c == CH_SPACE || c == CH_TAB || c == CH_COMMA)
        begin
            r = close_field();
            return 1'b1;
        end
        if (c == CH_MINUS && settings.allow_minus)
        begin
            fp_negative = 1'b1;
            return 1'b0;
        end
        d = digit_value(c);
        if (d == DIGIT_NONE)
        begin
            if (fp_width_left > 7'd0)
            begin
                fp_width_left--;
            end
            return 1'b0;
        end
        if (d >= rad)
        begin
            d = rad - 6'd1;
        end
        fp_acc        = fp_acc * {58'd0, rad} + {58'd0, d};
        fp_digit_seen = 1'b1;
        if (fp_width_left <= 7'd1)
        begin
            r = close_field();
            return 1'b1;
        end
        fp_width_left--;
        return 1'b0;
    endfunction

    task automatic send_char(input logic [7:0] c);
        int            gap;
        field_result_t r;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.char_in <= c;
        do @(posedge clk); while (chars_if.ready !== 1'b1);
        chars_sent++;
        if (parse_char(c, r))
        begin
            pending_fields.push_back(r);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    task automatic wait_drained();
        chars_if.valid <= 1'b0;
        while (pending_fields.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [5:0] rad, input logic pz, input logic [6:0] mw,
                                  input logic am, input logic [1:0] rs);
        logic [CFG_INDEX_WIDTH-1:0] regs [5];
        logic [CFG_DATA_WIDTH-1:0]  vals [5];
        if (fp_phase != PH_FIRST)
        begin
            send_char(CH_NUL);
        end
        wait_drained();
        regs = '{CFG_RADIX, CFG_PAD_ZERO, CFG_MAX_WIDTH, CFG_ALLOW_MINUS, CFG_RESULT_SIZE};
        vals = '{{1'b0, rad}, {6'd0, pz}, mw, {6'd0, am}, {5'd0, rs}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= regs[i];
            cfg_data     <= vals[i];
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        settings.radix       = rad;
        settings.pad_zero    = pz;
        settings.max_width   = mw;
        settings.allow_minus = am;
        settings.result_size = rs;
        settings_used++;
    endtask

    task automatic apply_random_settings();
        logic [5:0] rad;
        logic [6:0] mw;
        case ($urandom_range(0, 9))
            0: rad = RADIX_MIN;
            1: rad = RADIX_MAX;
            2: rad = 6'd8;
            3: rad = 6'd10;
            4: rad = 6'd16;
            5: rad = 6'($urandom_range(0, 1));
            6: rad = 6'($urandom_range(37, 63));
            default: rad = 6'($urandom_range(2, 36));
        endcase
        case ($urandom_range(0, 7))
            0: mw = 7'd0;
            1: mw = 7'd1;
            2: mw = 7'd2;
            3: mw = FIELD_WIDTH_MAX;
            4: mw = 7'($urandom_range(65, 127));
            default: mw = 7'($urandom_range(3, 20));
        endcase
        apply_settings(rad, 1'($urandom_range(0, 1)), mw, 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)));
    endtask

    function automatic logic [7:0] char_for(input int v, input bit upper);
        if (v < 10)
        begin
            return 8'(CH_ZERO + v);
        end
        return 8'((upper ? CH_UPPER_A : CH_LOWER_A) + v - 10);
    endfunction

    // An unbroken field has optional lead-in, blanks, zeros and sign, then digits and a closer.
    task automatic send_field(input bit broken);
        logic [7:0] closers [7];
        int         ndig;
        int         d;
        closers = '{CH_SPACE, CH_TAB, CH_COMMA, CH_NUL, CH_CR, CH_LF, CH_FF};
        if (broken)
        begin
            repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 5))
            0: send_char(CH_SPACE);
            1: send_char(CH_MINUS);
            2: send_char(8'($urandom_range(0, 255)));
            default:
            begin
            end
        endcase
        repeat ($urandom_range(0, 2)) send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) send_char(CH_ZERO);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_char(CH_MINUS);
        end
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 8);
        repeat (ndig)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_char(8'($urandom_range(0, 255)));
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                send_char(CH_MINUS);
            end
            else
            begin
                d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 35)
                                                : $urandom_range(0, effective_radix() - 1);
                send_char(char_for(d, 1'($urandom_range(0, 1))));
            end
        end
        send_char(closers[$urandom_range(0, 6)]);
    endtask

    task automatic test_directed();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        send_text(" -42,");
        send_text("7Z");
        send_char(CH_NUL);
        send_char(CH_LF);
        send_text("x#9");
        send_char(CH_CR);
        send_char(8'hFF);
        send_text("5");
        send_char(CH_FF);
        apply_settings(6'd16, 1'b1, 7'd3, 1'b0, SIZE_16);
        send_text("  00fF1");
        send_text("000");
        send_char(CH_LF);
    endtask

    task automatic test_setting_extremes();
        apply_settings(RADIX_MIN, 1'b0, 7'd1, 1'b0, SIZE_16);
        repeat (8) send_field(1'b0);
        apply_settings(RADIX_MAX, 1'b1, FIELD_WIDTH_MAX, 1'b1, SIZE_64);
        repeat (8) send_field(1'b0);
        apply_settings(6'd0, 1'b1, 7'd127, 1'b0, 2'd3);
        repeat (8) send_field(1'b0);
        apply_settings(6'd63, 1'b0, 7'd0, 1'b1, SIZE_64);
        repeat (8) send_field(1'b0);
    endtask

    // The result side holds off while the character side keeps offering items.
    task automatic test_backpressure();
        apply_settings(RADIX_MAX, 1'b0, 7'd0, 1'b1, SIZE_64);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        hold_cycles     = 300;
        repeat (25) send_field(1'b0);
        wait_drained();
        repeat (10) send_field(1'b0);
    endtask

    task automatic test_random_fields();
        while (chars_sent < TARGET_CHARS)
        begin
            apply_random_settings();
            sender_idles    = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            repeat (6) send_field($urandom_range(0, 9) == 0);
        end
    endtask

    initial
    begin
        int stall;
        results_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
            end
            else
            begin
                stall = receiver_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            end
            hold_cycles = 0;
            if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do @(posedge clk); while (results_if.valid !== 1'b1 && hold_cycles == 0);
        end
    end

    always @(posedge clk)
    begin
        field_result_t want;
        if (rst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1)
        begin
            if (pending_fields.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result item: expected none, actual %h converted %b",
                         $time, results_if.value, results_if.converted);
            end
            else
            begin
                want = pending_fields.pop_front();
                fields_checked++;
                if (results_if.value !== want.value)
                begin
                    mismatches++;
                    $display("%0t: value mismatch: expected %h, actual %h",
                             $time, want.value, results_if.value);
                end
                if (results_if.converted !== want.converted)
                begin
                    mismatches++;
                    $display("%0t: converted mismatch: expected %b, actual %b",
                             $time, want.converted, results_if.converted);
                end
            end
        end
    end

    initial
    begin
        mismatches       = 0;
        chars_sent       = 0;
        fields_checked   = 0;
        settings_used    = 0;
        hold_cycles      = 0;
        sender_idles     = 1'b0;
        receiver_stalls  = 1'b0;
        settings         = '{RADIX_RESET, PAD_ZERO_RESET, MAX_WIDTH_RESET, ALLOW_MINUS_RESET,
                             RESULT_SIZE_RESET};
        clear_field_state();
        rst_n            <= 1'b0;
        chars_if.valid   <= 1'b0;
        chars_if.char_in <= '0;
        cfg_write_en     <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_setting_extremes();
        test_backpressure();
        test_random_fields();
        wait_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d characters under %0d register settings and checked %0d parsed fields.",
                 chars_sent, settings_used, fields_checked);
        if (mismatches == 0)
        begin
            $display("** ascii_integer_field_parser: PASSED **");
        end
        else
        begin
            $display("** ascii_integer_field_parser: FAILED **");
        end
        $finish;
    end

endmodule
